>>> hw/rtl/brar_pkg.sv
// ----------------------------------------------------------------------------
// brar_pkg
// Shared types and constants for the binary relation arc revise block.
// ----------------------------------------------------------------------------
package brar_pkg;

  localparam int DATA_W = 64;
  localparam int IDX_W  = 6;

  typedef struct packed {
    logic load;
    logic init;
    logic rd_en;
    logic phase2;
    logic finish;
  } cmd_t;

  function automatic logic is_single(input logic [DATA_W-1:0] v);
    return (v != '0) && ((v & (v - DATA_W'(1))) == '0);
  endfunction

  function automatic logic is_multi(input logic [DATA_W-1:0] v);
    return (v != '0) && ((v & (v - DATA_W'(1))) != '0);
  endfunction

endpackage

>>> hw/rtl/brar_ctrl.sv
// ----------------------------------------------------------------------------
// brar_ctrl
// Sequencer: steps the two row sweeps and raises the result strobe.
// ----------------------------------------------------------------------------
module brar_ctrl #(
  parameter int DOMAIN_VALUES = 64,
  parameter int ADDR_W        = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mode,
  output logic              busy,
  output logic              done,
  output brar_pkg::cmd_t    cmd,
  output logic [ADDR_W-1:0] rd_addr
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] addr;
  logic              last;

  assign last    = (addr == ADDR_W'(DOMAIN_VALUES - 1));
  assign busy    = (state != ST_IDLE);
  assign rd_addr = addr;

  always_comb begin
    cmd.load   = start && !busy && !mode;
    cmd.init   = start && !busy && mode;
    cmd.rd_en  = (state == ST_PASS1) || (state == ST_PASS2);
    cmd.phase2 = (state == ST_PASS2);
    cmd.finish = (state == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      addr  <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_FINISH);
      unique case (state)
        ST_IDLE: begin
          addr <= '0;
          if (start && mode) begin
            state <= ST_PASS1;
          end
        end
        ST_PASS1: begin
          addr <= last ? '0 : addr + ADDR_W'(1);
          if (last) begin
            state <= ST_PASS2;
          end
        end
        ST_PASS2: begin
          addr <= last ? '0 : addr + ADDR_W'(1);
          if (last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/brar_dpath.sv
// ----------------------------------------------------------------------------
// brar_dpath
// Relation row memory, support accumulators and result registers.
// ----------------------------------------------------------------------------
module brar_dpath #(
  parameter int DOMAIN_VALUES = 64,
  parameter int ADDR_W        = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  brar_pkg::cmd_t                 cmd,
  input  logic [ADDR_W-1:0]              rd_addr,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic [brar_pkg::IDX_W-1:0]     row_index,
  input  logic [brar_pkg::DATA_W-1:0]    row_bits,
  input  logic [brar_pkg::DATA_W-1:0]    x_domain,
  input  logic [brar_pkg::DATA_W-1:0]    y_domain,
  output logic [brar_pkg::DATA_W-1:0]    x_domain_out,
  output logic [brar_pkg::DATA_W-1:0]    y_domain_out,
  output logic                           x_changed,
  output logic                           y_changed,
  output logic                           conflict
);

  localparam logic [brar_pkg::DATA_W-1:0] DOM_MASK =
    (DOMAIN_VALUES >= brar_pkg::DATA_W) ? {brar_pkg::DATA_W{1'b1}} :
    ((brar_pkg::DATA_W'(1) << DOMAIN_VALUES) - brar_pkg::DATA_W'(1));

  logic [brar_pkg::DATA_W-1:0] mem [DOMAIN_VALUES];
  logic [brar_pkg::DATA_W-1:0] rdata;
  logic [ADDR_W-1:0]           ridx;
  logic                        rvalid;
  logic                        rphase2;
  logic                        support_mode;

  logic [brar_pkg::DATA_W-1:0] xd;
  logic [brar_pkg::DATA_W-1:0] yd;
  logic [brar_pkg::DATA_W-1:0] xs;
  logic [brar_pkg::DATA_W-1:0] sup;

  logic [brar_pkg::DATA_W-1:0] allowed;
  logic [brar_pkg::DATA_W-1:0] xn;
  logic [brar_pkg::DATA_W-1:0] yn;
  logic                        x_multi;
  logic                        y_multi;
  logic                        both_single;
  logic                        row_ok;

  assign row_ok      = (32'(row_index) < DOMAIN_VALUES);
  assign allowed     = (support_mode ? rdata : ~rdata) & DOM_MASK;
  assign x_multi     = brar_pkg::is_multi(xd);
  assign y_multi     = brar_pkg::is_multi(yd);
  assign both_single = brar_pkg::is_single(xd) && brar_pkg::is_single(yd);
  assign xn          = x_multi ? xs : xd;
  assign yn          = y_multi ? (yd & sup) : yd;

  always_ff @(posedge clk) begin
    if (cmd.load && row_ok) begin
      mem[row_index[ADDR_W-1:0]] <= row_bits;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      support_mode <= 1'b1;
      rvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        support_mode <= cfg_wdata;
      end
      rvalid <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    ridx    <= rd_addr;
    rphase2 <= cmd.phase2;
    if (cmd.init) begin
      xd  <= x_domain & DOM_MASK;
      yd  <= y_domain & DOM_MASK;
      xs  <= x_domain & DOM_MASK;
      sup <= '0;
    end else if (rvalid && !rphase2) begin
      if (xd[ridx] && ((allowed & yd) == '0)) begin
        xs[ridx] <= 1'b0;
      end
    end else if (rvalid && rphase2) begin
      if (xn[ridx]) begin
        sup <= sup | allowed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      priority if (both_single) begin
        x_domain_out <= xd;
        y_domain_out <= yd;
        x_changed    <= 1'b0;
        y_changed    <= 1'b0;
        conflict     <= (xs == '0);
      end else if (x_multi && (xn == '0)) begin
        x_domain_out <= '0;
        y_domain_out <= yd;
        x_changed    <= 1'b1;
        y_changed    <= 1'b0;
        conflict     <= 1'b1;
      end else begin
        x_domain_out <= xn;
        y_domain_out <= yn;
        x_changed    <= x_multi && (xn != xd);
        y_changed    <= y_multi && (yn != yd);
        conflict     <= y_multi && (yn == '0);
      end
    end
  end

endmodule

>>> hw/rtl/binary_relation_arc_revise_top.sv
// ----------------------------------------------------------------------------
// binary_relation_arc_revise_top
// Arc revision of two domains against a stored binary relation table.
// ----------------------------------------------------------------------------
// A load transfer gives no result.
// A propagate transfer gives its result after two sweeps over the row memory,
// one read per cycle; the next transfer may start in the cycle of the strobe.
// Reset returns the sequencer to idle and support_mode to 1; rows are
// undefined until loaded. The receiver cannot stall.
module binary_relation_arc_revise_top #(
  parameter int DOMAIN_VALUES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  output logic                        done,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        mode,
  input  logic [brar_pkg::IDX_W-1:0]  row_index,
  input  logic [brar_pkg::DATA_W-1:0] row_bits,
  input  logic [brar_pkg::DATA_W-1:0] x_domain,
  input  logic [brar_pkg::DATA_W-1:0] y_domain,
  output logic [brar_pkg::DATA_W-1:0] x_domain_out,
  output logic [brar_pkg::DATA_W-1:0] y_domain_out,
  output logic                        x_changed,
  output logic                        y_changed,
  output logic                        conflict
);

  localparam int ADDR_W = (DOMAIN_VALUES > 1) ? $clog2(DOMAIN_VALUES) : 1;

  brar_pkg::cmd_t    cmd;
  logic [ADDR_W-1:0] rd_addr;

  brar_ctrl #(
    .DOMAIN_VALUES(DOMAIN_VALUES),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .rd_addr(rd_addr)
  );

  brar_dpath #(
    .DOMAIN_VALUES(DOMAIN_VALUES),
    .ADDR_W       (ADDR_W)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .row_index   (row_index),
    .row_bits    (row_bits),
    .x_domain    (x_domain),
    .y_domain    (y_domain),
    .x_domain_out(x_domain_out),
    .y_domain_out(y_domain_out),
    .x_changed   (x_changed),
    .y_changed   (y_changed),
    .conflict    (conflict)
  );

  a_prop_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode) |=> busy)
    else $error("propagate transfer did not start a sweep");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a sweep in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !mode) |=> !busy && !done)
    else $error("load transfer started a sweep or a result");

endmodule

>>> verif/binary_relation_arc_revise_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_relation_arc_revise_top_test
// Self-checking bench for the arc revise block: row loads and domain pruning.
// ----------------------------------------------------------------------------
// The bench fills the whole relation table, runs a short directed set of
// transfers (singleton pairs, wipeouts of either domain, empty and full
// domains, both relation polarities), then runs random phases that mix row
// loads with propagate transfers. Domains and rows are drawn sparse, dense
// or narrow so that pruning, wipeouts and conflicts happen often. A local
// model of the table and polarity predicts each pruning result, and every
// strobed result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module binary_relation_arc_revise_top_test;

  localparam int DATA_W            = brar_pkg::DATA_W;
  localparam int IDX_W             = brar_pkg::IDX_W;
  localparam bit OP_LOAD           = 1'b0;
  localparam bit OP_PROPAGATE      = 1'b1;
  localparam bit SUPPORT_FORBIDDEN = 1'b0;
  localparam bit SUPPORT_ALLOWED   = 1'b1;
  localparam int ROWS              = 64;
  localparam int SETTLE_CYCLES     = 2 * ROWS + 12;
  localparam int PHASE_ITEMS       = 210;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct {
    word_t x_dom;
    word_t y_dom;
    logic  x_chg;
    logic  y_chg;
    logic  clash;
  } prune_result_t;

  class domain_prune_board;
    word_t         rows [ROWS];
    bit            support;
    prune_result_t expected_prunes [$];
    int            errors;

    function new();
      support = SUPPORT_ALLOWED;
      errors  = 0;
      foreach (rows[i]) rows[i] = '0;
    endfunction

    function void set_support(bit v);
      support = v;
    endfunction

    function int outstanding();
      return expected_prunes.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function word_t partners(int a);
      return support ? rows[a] : ~rows[a];
    endfunction

    function logic pair_forbidden(word_t xd, word_t yd);
      int a;
      int b;
      word_t p;
      a = 0;
      b = 0;
      for (int i = ROWS - 1; i >= 0; i--) begin
        if (xd[i]) a = i;
        if (yd[i]) b = i;
      end
      p = partners(a);
      return !p[b];
    endfunction

    function prune_result_t prune_domains(word_t xd, word_t yd);
      prune_result_t r;
      word_t xn;
      word_t yn;
      word_t sup;
      r.x_dom = xd;
      r.y_dom = yd;
      r.x_chg = 1'b0;
      r.y_chg = 1'b0;
      r.clash = 1'b0;
      if ($countones(xd) == 1 && $countones(yd) == 1) begin
        r.clash = pair_forbidden(xd, yd);
        return r;
      end
      xn = xd;
      if ($countones(xd) > 1) begin
        for (int a = 0; a < ROWS; a++) begin
          if (xd[a] && (partners(a) & yd) == '0) xn[a] = 1'b0;
        end
        r.x_dom = xn;
        r.x_chg = (xn != xd);
        if (xn == '0) begin
          r.clash = 1'b1;
          return r;
        end
      end
      yn = yd;
      if ($countones(yd) > 1) begin
        sup = '0;
        for (int a = 0; a < ROWS; a++) begin
          if (xn[a]) sup |= partners(a);
        end
        yn = yd & sup;
        r.y_dom = yn;
        r.y_chg = (yn != yd);
        if (yn == '0) begin
          r.clash = 1'b1;
          return r;
        end
      end
      if ($countones(xn) == 1 && $countones(yn) == 1) r.clash = pair_forbidden(xn, yn);
      return r;
    endfunction

    function void note_transfer(logic op, logic [IDX_W-1:0] idx, word_t bits,
                                word_t xd, word_t yd);
      if (op == OP_LOAD) rows[idx] = bits;
      else expected_prunes.insert(expected_prunes.size(), prune_domains(xd, yd));
    endfunction

    task check_result(word_t xo, word_t yo, logic xc, logic yc, logic cf);
      prune_result_t e;
      if (expected_prunes.size() == 0) begin
        report("result strobed with no propagate outstanding");
        return;
      end
      e = expected_prunes.pop_front();
      if (xo !== e.x_dom) report($sformatf("x_domain_out %h, want %h", xo, e.x_dom));
      if (yo !== e.y_dom) report($sformatf("y_domain_out %h, want %h", yo, e.y_dom));
      if (xc !== e.x_chg) report($sformatf("x_changed %b, want %b", xc, e.x_chg));
      if (yc !== e.y_chg) report($sformatf("y_changed %b, want %b", yc, e.y_chg));
      if (cf !== e.clash) report($sformatf("conflict %b, want %b", cf, e.clash));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              done;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              mode = OP_LOAD;
  logic [IDX_W-1:0]  row_index = '0;
  word_t             row_bits = '0;
  word_t             x_domain = '0;
  word_t             y_domain = '0;
  word_t             x_domain_out;
  word_t             y_domain_out;
  logic              x_changed;
  logic              y_changed;
  logic              conflict;

  domain_prune_board board = new();
  bit                burst = 1'b0;

  binary_relation_arc_revise_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mode         (mode),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .x_domain     (x_domain),
    .y_domain     (y_domain),
    .x_domain_out (x_domain_out),
    .y_domain_out (y_domain_out),
    .x_changed    (x_changed),
    .y_changed    (y_changed),
    .conflict     (conflict)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_result(x_domain_out, y_domain_out, x_changed, y_changed, conflict);
      if (start && !busy) board.note_transfer(mode, row_index, row_bits, x_domain, y_domain);
      if (cfg_we) board.set_support(cfg_wdata);
    end
  end

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic word_t rand_row();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, ROWS - 1);
      3: return ~(word_t'(1) << $urandom_range(0, ROWS - 1));
      4, 5: return rand_word() & rand_word() & rand_word();
      6: return rand_word() | rand_word() | rand_word();
      7, 8: return rand_word() & word_t'(8'hff) | (rand_word() & rand_word()
                   & rand_word() & rand_word());
      default: return rand_word();
    endcase
  endfunction

  function automatic word_t rand_domain();
    case ($urandom_range(0, 11))
      0: return '0;
      1, 2: return word_t'(1) << $urandom_range(0, ROWS - 1);
      3: return (word_t'(1) << $urandom_range(0, ROWS - 1))
                | (word_t'(1) << $urandom_range(0, ROWS - 1));
      4: return word_t'(1) << $urandom_range(0, 7);
      5, 6: return rand_word() & word_t'(8'hff);
      7: return rand_word() & rand_word() & rand_word();
      8: return '1;
      default: return rand_word();
    endcase
  endfunction

  task automatic drive_item(logic op, logic [IDX_W-1:0] idx, word_t bits,
                            word_t xd, word_t yd);
    int gap;
    if ($urandom_range(0, 19) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    mode = op;
    row_index = idx;
    row_bits = bits;
    x_domain = xd;
    y_domain = yd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_load(logic [IDX_W-1:0] idx, word_t bits);
    drive_item(OP_LOAD, idx, bits, rand_word(), rand_word());
  endtask

  task automatic send_propagate(word_t xd, word_t yd);
    drive_item(OP_PROPAGATE, IDX_W'($urandom()), rand_word(), xd, yd);
  endtask

  task automatic drain_block();
    @(negedge clk);
    start = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_support(bit v);
    drain_block();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = $urandom_range(0, 1);
  endtask

  initial begin
    int guard;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Every row is written before any propagate, so no sweep reads an unset row.
    for (int i = 0; i < ROWS; i++) send_load(IDX_W'(i), rand_row());

    send_load(IDX_W'(0), '1);
    send_load(IDX_W'(1), '0);
    send_load(IDX_W'(2), word_t'(1) << 5);
    send_load(IDX_W'(ROWS - 1), (word_t'(1) << (ROWS - 1)) | word_t'(1));
    send_propagate(word_t'(1), word_t'(1) << 7);
    send_propagate(word_t'(1) << 1, word_t'(1) << 7);
    send_propagate(word_t'('b110), (word_t'(1) << 5) | (word_t'(1) << 6));
    send_propagate(word_t'('b110), word_t'(1) << 6);
    send_propagate(word_t'(1) << 2, (word_t'(1) << 6) | (word_t'(1) << 7));
    send_propagate('0, word_t'('b11));
    send_propagate('1, '0);
    send_propagate('0, '0);
    send_propagate('1, '1);
    send_propagate(word_t'(1) << (ROWS - 1), word_t'(1) << (ROWS - 1));
    send_propagate(word_t'(1) << (ROWS - 1), word_t'(1) << (ROWS - 2));
    send_propagate('1, word_t'(1));

    write_support(SUPPORT_FORBIDDEN);
    send_propagate(word_t'(1) << 1, word_t'(1) << 7);
    send_propagate(word_t'(1), word_t'(1) << 7);
    send_propagate(word_t'('b110), (word_t'(1) << 5) | (word_t'(1) << 6));
    send_propagate(word_t'(1) << (ROWS - 1), word_t'(1) << (ROWS - 2));
    send_propagate('1, '1);
    send_propagate(word_t'('b111), word_t'(1) << 5);

    for (int p = 0; p < 6; p++) begin
      write_support((p == 1 || p == 3 || p == 4) ? SUPPORT_FORBIDDEN : SUPPORT_ALLOWED);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) == 0) send_load(IDX_W'($urandom()), rand_row());
        else send_propagate(rand_domain(), rand_domain());
      end
    end

    @(negedge clk);
    start = 1'b0;
    guard = 0;
    while (board.outstanding() != 0 && guard < 20 * SETTLE_CYCLES) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.outstanding() != 0)
      board.report($sformatf("%0d propagate results never arrived", board.outstanding()));

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/brar_pkg.sv
hw/rtl/brar_ctrl.sv
hw/rtl/brar_dpath.sv
hw/rtl/binary_relation_arc_revise_top.sv
verif/binary_relation_arc_revise_top_test.sv
